// ===== rtl/core/acex_pkg.sv =====
`timescale 1ns / 1ps
package acex_pkg;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0, OP_SBC = 6'd1, OP_AND = 6'd2, OP_ORA = 6'd3, OP_EOR = 6'd4,
		OP_ASL = 6'd5, OP_LSR = 6'd6, OP_ROL = 6'd7, OP_ROR = 6'd8, OP_CMP = 6'd9,
		OP_CPX = 6'd10, OP_CPY = 6'd11, OP_BIT = 6'd12, OP_BCC = 6'd13, OP_BCS = 6'd14,
		OP_BEQ = 6'd15, OP_BNE = 6'd16, OP_BMI = 6'd17, OP_BPL = 6'd18, OP_BVC = 6'd19,
		OP_BVS = 6'd20, OP_JMP = 6'd21, OP_JSR = 6'd22, OP_RTS = 6'd23, OP_RTI = 6'd24,
		OP_BRK = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27, OP_LDY = 6'd28, OP_STA = 6'd29,
		OP_STX = 6'd30, OP_STY = 6'd31, OP_INC = 6'd32, OP_DEC = 6'd33, OP_INX = 6'd34,
		OP_DEX = 6'd35, OP_INY = 6'd36, OP_DEY = 6'd37, OP_TAX = 6'd38, OP_TAY = 6'd39,
		OP_TXA = 6'd40, OP_TYA = 6'd41, OP_TSX = 6'd42, OP_TXS = 6'd43, OP_PHA = 6'd44,
		OP_PLA = 6'd45, OP_PHP = 6'd46, OP_PLP = 6'd47, OP_CLC = 6'd48, OP_SEC = 6'd49,
		OP_CLI = 6'd50, OP_SEI = 6'd51, OP_CLV = 6'd52, OP_CLD = 6'd53, OP_SED = 6'd54,
		OP_NOP = 6'd55
	} op_t;

	// stack access classes
	typedef enum logic [2:0] {
		SK_NONE = 3'd0, SK_PUSH1 = 3'd1, SK_PULL1 = 3'd2, SK_JSR = 3'd3,
		SK_RTS = 3'd4, SK_RTI = 3'd5, SK_BRK = 3'd6
	} stk_t;

	typedef enum logic [1:0] {
		EX_IDLE = 2'd0, EX_STEP1 = 2'd1, EX_STEP2 = 2'd2, EX_STEP3 = 2'd3
	} ex_state_t;

	localparam logic [7:0] FLAG_C = 8'h01;
	localparam logic [7:0] FLAG_Z = 8'h02;
	localparam logic [7:0] FLAG_I = 8'h04;
	localparam logic [7:0] FLAG_D = 8'h08;
	localparam logic [7:0] FLAG_B = 8'h10;
	localparam logic [7:0] FLAG_U = 8'h20;
	localparam logic [7:0] FLAG_V = 8'h40;
	localparam logic [7:0] FLAG_N = 8'h80;
	localparam logic [7:0] PULL_MASK = 8'hCF;
	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] P_RESET = 8'h24;

	typedef struct packed {
		logic [5:0]  op;
		logic [7:0]  operand;
		logic        on_acc;
		logic [15:0] jump_target;
		logic [15:0] pc;
	} req_t;

	typedef struct packed {
		req_t req;
		stk_t stk;
	} cls_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic        write_enable;
		logic [7:0]  write_data;
		logic [7:0]  acc_value;
		logic [7:0]  x_value;
		logic [7:0]  y_value;
		logic [7:0]  sp_value;
		logic [7:0]  status_value;
	} rsp_t;

	localparam int QDEPTH = 2;

endpackage

// ===== rtl/core/acex_if.sv =====
`timescale 1ns / 1ps
interface acex_req_if;
	import acex_pkg::*;
	logic valid;
	logic ready;
	logic [5:0]  req_type;
	logic [7:0]  operand;
	logic        on_accumulator;
	logic [15:0] jump_target;
	logic [15:0] pc_after_fetch;
	modport source (output valid, req_type, operand, on_accumulator, jump_target,
		pc_after_fetch, input ready);
	modport sink (input valid, req_type, operand, on_accumulator, jump_target,
		pc_after_fetch, output ready);
endinterface

interface acex_rsp_if;
	logic valid;
	logic ready;
	logic [15:0] next_pc;
	logic        write_enable;
	logic [7:0]  write_data;
	logic [7:0]  acc_value;
	logic [7:0]  x_value;
	logic [7:0]  y_value;
	logic [7:0]  sp_value;
	logic [7:0]  status_value;
	modport source (output valid, next_pc, write_enable, write_data, acc_value, x_value,
		y_value, sp_value, status_value, input ready);
	modport sink (input valid, next_pc, write_enable, write_data, acc_value, x_value,
		y_value, sp_value, status_value, output ready);
endinterface

// ===== rtl/core/acex_front.sv =====
`timescale 1ns / 1ps
module acex_front (
	input  logic            clk,
	input  logic            arst_n,
	acex_req_if.sink        req,
	output acex_pkg::cls_t  q_data,
	output logic            q_valid,
	input  logic            q_pop
);
	import acex_pkg::*;

	cls_t            mem_q [QDEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	cls_t            cls;
	logic            push;

	always_comb begin
		cls.req.op          = req.req_type;
		cls.req.operand     = req.operand;
		cls.req.on_acc      = req.on_accumulator;
		cls.req.jump_target = req.jump_target;
		cls.req.pc          = req.pc_after_fetch;
		unique case (req.req_type)
			OP_PHA, OP_PHP: cls.stk = SK_PUSH1;
			OP_PLA, OP_PLP: cls.stk = SK_PULL1;
			OP_JSR:         cls.stk = SK_JSR;
			OP_RTS:         cls.stk = SK_RTS;
			OP_RTI:         cls.stk = SK_RTI;
			OP_BRK:         cls.stk = SK_BRK;
			default:        cls.stk = SK_NONE;
		endcase
	end

	assign req.ready = (cnt_q != 2'(QDEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDEPTH)) else $error("queue overflow");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
endmodule

// ===== rtl/core/acex_back.sv =====
`timescale 1ns / 1ps
module acex_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  acex_pkg::cls_t  q_data,
	input  logic            q_valid,
	output logic            q_pop,
	acex_rsp_if.source      rsp
);
	import acex_pkg::*;

	logic [7:0]  stack_q [256];
	logic [7:0]  a_q, x_q, y_q, sp_q, p_q;
	logic [15:0] brk_vec_q;
	ex_state_t   state_q, state_d;
	logic [7:0]  rd_s1;
	logic [7:0]  lo_q;
	logic        out_valid_q;
	rsp_t        out_q;

	// stack port control
	logic        st_we;
	logic [7:0]  st_waddr, st_wdata, st_raddr;
	logic        st_re;

	// single-step outcome
	logic [7:0]  a_n, x_n, y_n, sp_n, p_n, wd, v, m, sum8, diff;
	logic [8:0]  sum;
	logic [15:0] npc, tpc, off;
	logic        we, take, cin, fin, out_free;
	logic [7:0]  cmp_reg;

	assign out_free = !out_valid_q || rsp.ready;
	assign m = q_data.req.operand;

	always_ff @(posedge clk) begin
		if (st_we) stack_q[st_waddr] <= st_wdata;
		if (st_re) rd_s1 <= stack_q[st_raddr];
	end

	always_comb begin
		state_d  = state_q;
		st_we    = 1'b0; st_waddr = sp_q; st_wdata = a_q;
		st_re    = 1'b0; st_raddr = sp_q + 8'd1;
		a_n = a_q; x_n = x_q; y_n = y_q; sp_n = sp_q; p_n = p_q;
		we = 1'b0; wd = 8'd0; take = 1'b0; npc = q_data.req.pc;
		fin = 1'b0; v = 8'd0; sum = 9'd0; sum8 = 8'd0; diff = 8'd0; cin = 1'b0;
		cmp_reg = a_q; tpc = 16'd0;
		off = {{8{m[7]}}, m};
		unique case (state_q)
			EX_IDLE: begin
				if (q_valid && out_free) begin
					case (q_data.stk)
						SK_NONE: fin = 1'b1;
						SK_PUSH1: begin
							st_we = 1'b1;
							st_wdata = (q_data.req.op == OP_PHA) ? a_q : (p_q | FLAG_B | FLAG_U);
							sp_n = sp_q - 8'd1; fin = 1'b1;
						end
						SK_PULL1, SK_RTS, SK_RTI: begin
							st_re = 1'b1; sp_n = sp_q + 8'd1; state_d = EX_STEP1;
						end
						SK_JSR: begin
							tpc = q_data.req.pc - 16'd1;
							st_we = 1'b1; st_wdata = tpc[15:8];
							sp_n = sp_q - 8'd1; state_d = EX_STEP1;
						end
						SK_BRK: begin
							tpc = q_data.req.pc + 16'd1;
							st_we = 1'b1; st_wdata = tpc[15:8];
							sp_n = sp_q - 8'd1; state_d = EX_STEP1;
						end
						default: fin = 1'b1;
					endcase
					if (fin) begin
						unique case (q_data.req.op) inside
							OP_ADC, OP_SBC: begin
								v = (q_data.req.op == OP_SBC) ? ~m : m;
								sum = {1'b0, a_q} + {1'b0, v} + {8'd0, p_q[0]};
								sum8 = sum[7:0];
								a_n = sum8;
								p_n[0] = sum[8];
								p_n[6] = ((a_q ^ sum8) & (v ^ sum8) & 8'h80) != 8'd0;
								v = sum8;
							end
							OP_AND: begin a_n = a_q & m; v = a_n; end
							OP_ORA: begin a_n = a_q | m; v = a_n; end
							OP_EOR: begin a_n = a_q ^ m; v = a_n; end
							OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
								v = q_data.req.on_acc ? a_q : m;
								cin = p_q[0];
								case (q_data.req.op)
									OP_ASL: begin p_n[0] = v[7]; v = {v[6:0], 1'b0}; end
									OP_LSR: begin p_n[0] = v[0]; v = {1'b0, v[7:1]}; end
									OP_ROL: begin p_n[0] = v[7]; v = {v[6:0], cin}; end
									OP_ROR: begin p_n[0] = v[0]; v = {cin, v[7:1]}; end
									OP_INC: v = v + 8'd1;
									default: v = v - 8'd1;
								endcase
								if (q_data.req.on_acc) a_n = v;
								else begin we = 1'b1; wd = v; end
							end
							OP_CMP, OP_CPX, OP_CPY: begin
								cmp_reg = (q_data.req.op == OP_CMP) ? a_q :
									(q_data.req.op == OP_CPX) ? x_q : y_q;
								diff = cmp_reg - m;
								p_n[1] = cmp_reg == m;
								p_n[0] = cmp_reg >= m;
								p_n[7] = diff[7];
							end
							OP_BIT: begin
								p_n[1] = (a_q & m) == 8'd0;
								p_n[7] = m[7]; p_n[6] = m[6];
							end
							OP_BCC: take = !p_q[0];
							OP_BCS: take = p_q[0];
							OP_BEQ: take = p_q[1];
							OP_BNE: take = !p_q[1];
							OP_BMI: take = p_q[7];
							OP_BPL: take = !p_q[7];
							OP_BVC: take = !p_q[6];
							OP_BVS: take = p_q[6];
							OP_JMP: npc = q_data.req.jump_target;
							OP_LDA: begin a_n = m; v = m; end
							OP_LDX: begin x_n = m; v = m; end
							OP_LDY: begin y_n = m; v = m; end
							OP_STA: begin we = 1'b1; wd = a_q; end
							OP_STX: begin we = 1'b1; wd = x_q; end
							OP_STY: begin we = 1'b1; wd = y_q; end
							OP_INX: begin x_n = x_q + 8'd1; v = x_n; end
							OP_DEX: begin x_n = x_q - 8'd1; v = x_n; end
							OP_INY: begin y_n = y_q + 8'd1; v = y_n; end
							OP_DEY: begin y_n = y_q - 8'd1; v = y_n; end
							OP_TAX: begin x_n = a_q; v = a_q; end
							OP_TAY: begin y_n = a_q; v = a_q; end
							OP_TXA: begin a_n = x_q; v = x_q; end
							OP_TYA: begin a_n = y_q; v = y_q; end
							OP_TSX: begin x_n = sp_q; v = sp_q; end
							OP_TXS: sp_n = x_q;
							OP_CLC: p_n[0] = 1'b0;
							OP_SEC: p_n[0] = 1'b1;
							OP_CLI: p_n[2] = 1'b0;
							OP_SEI: p_n[2] = 1'b1;
							OP_CLV: p_n[6] = 1'b0;
							OP_CLD: p_n[3] = 1'b0;
							OP_SED: p_n[3] = 1'b1;
							default: ;
						endcase
						if (q_data.req.op inside {OP_ADC, OP_SBC, OP_AND, OP_ORA, OP_EOR,
							OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC, OP_LDA, OP_LDX,
							OP_LDY, OP_INX, OP_DEX, OP_INY, OP_DEY, OP_TAX, OP_TAY, OP_TXA,
							OP_TYA, OP_TSX}) begin
							p_n[1] = v == 8'd0;
							p_n[7] = v[7];
						end
						if (take) npc = q_data.req.pc + off;
					end
				end
			end
			EX_STEP1: begin
				case (q_data.stk)
					SK_PULL1: begin
						fin = 1'b1;
						if (q_data.req.op == OP_PLA) begin
							a_n = rd_s1; p_n[1] = rd_s1 == 8'd0; p_n[7] = rd_s1[7];
						end else p_n = (rd_s1 & PULL_MASK) | FLAG_U;
					end
					SK_RTS, SK_RTI: begin
						if (q_data.stk == SK_RTI) p_n = (rd_s1 & PULL_MASK) | FLAG_U;
						st_re = 1'b1; sp_n = sp_q + 8'd1; state_d = EX_STEP2;
					end
					SK_JSR: begin
						tpc = q_data.req.pc - 16'd1;
						st_we = 1'b1; st_wdata = tpc[7:0]; sp_n = sp_q - 8'd1;
						npc = q_data.req.jump_target; fin = 1'b1;
					end
					default: begin
						tpc = q_data.req.pc + 16'd1;
						st_we = 1'b1; st_wdata = tpc[7:0]; sp_n = sp_q - 8'd1;
						state_d = EX_STEP2;
					end
				endcase
			end
			EX_STEP2: begin
				case (q_data.stk)
					SK_RTS: begin
						npc = {rd_s1, lo_q} + 16'd1; fin = 1'b1;
					end
					SK_RTI: begin
						st_re = 1'b1; sp_n = sp_q + 8'd1; state_d = EX_STEP3;
					end
					default: begin
						st_we = 1'b1; st_wdata = p_q | FLAG_B | FLAG_U;
						sp_n = sp_q - 8'd1; p_n = p_q | FLAG_I;
						npc = brk_vec_q; fin = 1'b1;
					end
				endcase
			end
			EX_STEP3: begin
				npc = {rd_s1, lo_q}; fin = 1'b1;
			end
		endcase
		if (fin) state_d = EX_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0; sp_q <= SP_RESET; p_q <= P_RESET;
			brk_vec_q <= 16'd0; state_q <= EX_IDLE; out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) brk_vec_q <= cfg_wdata;
			if (fin) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			a_q <= a_n; x_q <= x_n; y_q <= y_n; sp_q <= sp_n; p_q <= p_n;
			state_q <= state_d;
		end
	end

	// low byte of the return address
	always_ff @(posedge clk) begin
		if ((state_q == EX_STEP1 && q_data.stk == SK_RTS) ||
			(state_q == EX_STEP2 && q_data.stk == SK_RTI)) lo_q <= rd_s1;
		if (fin) begin
			out_q.next_pc <= npc; out_q.write_enable <= we; out_q.write_data <= wd;
			out_q.acc_value <= a_n; out_q.x_value <= x_n; out_q.y_value <= y_n;
			out_q.sp_value <= sp_n; out_q.status_value <= p_n;
		end
	end

	assign q_pop = fin;

	assign rsp.valid        = out_valid_q;
	assign rsp.next_pc      = out_q.next_pc;
	assign rsp.write_enable = out_q.write_enable;
	assign rsp.write_data   = out_q.write_data;
	assign rsp.acc_value    = out_q.acc_value;
	assign rsp.x_value      = out_q.x_value;
	assign rsp.y_value      = out_q.y_value;
	assign rsp.sp_value     = out_q.sp_value;
	assign rsp.status_value = out_q.status_value;

	a_fin_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("finish without queued item");
	a_u_bit: assert property (@(posedge clk) disable iff (!arst_n)
		p_q[5]) else $error("unused status bit cleared");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> $stable(out_q)) else $error("result lost");
endmodule

// ===== rtl/core/accumulator_cpu_execute_unit_top.sv =====
`timescale 1ns / 1ps
// 6502 execute unit, binary mode
// req channel: one fetched instruction per transfer (req_type, operand,
//   on_accumulator, jump_target, pc_after_fetch)
// rsp channel: one result per instruction (next pc, optional memory write,
//   A, X, Y, SP and status after execution)
// cfg_we/cfg_wdata load the break vector used by brk
// a two-entry queue separates the accepting front from the executing back,
// so new requests are taken while a result waits on the output register
// plain instructions and pha/php finish in EX_IDLE; pla/plp/jsr also pass
//   EX_STEP1, rts and brk EX_STEP1 and EX_STEP2, rti EX_STEP1 to EX_STEP3
// throughput: one instruction per cycle for plain instructions and pha/php
//   while the receiver takes results; the multi-step ones hold the back end
//   due to the one write and one registered read port of the stack page
// reset clears A, X, Y, sets SP to fd and status to 24, break vector to 0;
//   the stack page holds no defined value until written
// a stalled receiver holds the result; the queue fills and req.ready drops
module accumulator_cpu_execute_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	acex_req_if.sink    req,
	acex_rsp_if.source  rsp
);
	import acex_pkg::*;

	cls_t q_data;
	logic q_valid;
	logic q_pop;

	acex_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
	);

	acex_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .rsp(rsp)
	);
endmodule
